### sv/chm_pkg.sv
// Package for the chained hash map unit: sizes, index types and codes.
// Depends on nothing; every module of the unit imports it.
`default_nettype none
package chm_pkg;
    localparam int BUCKETS = 4;
    localparam int ENTRIES = 64;
    localparam int BW = $clog2(BUCKETS);
    localparam int IW = $clog2(ENTRIES) + 1;
    localparam int AW = $clog2(ENTRIES);
    localparam logic [IW-1:0] NIL = IW'(ENTRIES);

    localparam logic [1:0] OP_PUT = 2'd0;
    localparam logic [1:0] OP_GET = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef logic [IW-1:0] idx_t;

    // One write request to the entry store.
    typedef struct packed {
        logic        we_link;
        logic        we_kd;
        logic [AW-1:0] addr;
        idx_t        link;
        logic [31:0] key;
        logic [31:0] data;
    } ent_wr_t;

    // True when an index names a real entry.
    function automatic logic is_valid(input idx_t i);
        return i < NIL;
    endfunction
endpackage
`default_nettype wire

### sv/chained_hash_map_unit.sv
// Top level of the chained hash map unit: sequencer plus entry store.
// Depends on chm_pkg, chm_ctrl and chm_entry_mem.
//
// A put reads the free-list head (S_PUTRD) and then writes the new entry
// at the head of its bucket chain (S_PUTWR); when the pool is full, or for an
// unused opcode, the result comes straight from idle. A get or remove walks
// the chain with one entry-memory read per entry (S_WALK, then S_CHECK), and a
// remove that unlinks a non-head entry adds a link write in S_FREE; a miss
// ends in S_WALK at the end of the chain. Start is taken only while
// busy is low, and each result shows for one cycle with done high; the
// receiver cannot stall, so every result word must be captured in that cycle.
`default_nettype none
module chained_hash_map_unit
    import chm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [1:0]  opcode,
    input  wire logic signed [31:0] key,
    input  wire logic signed [31:0] data_in,
    output logic             busy,
    output logic             done,
    output logic [1:0]       status,
    output logic signed [31:0] data_out
);
    logic [AW-1:0] rd_addr;
    ent_wr_t wr;
    logic [31:0] rd_key, rd_data;
    idx_t rd_link;

    // Sequencer.
    chm_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .opcode(opcode),
        .key(key), .data_in(data_in), .busy(busy), .done(done),
        .status(status), .data_out(data_out), .rd_addr(rd_addr), .wr(wr),
        .rd_key(rd_key), .rd_data(rd_data), .rd_link(rd_link)
    );

    // Entry store.
    chm_entry_mem u_mem (
        .clk(clk), .rst_n(rst_n), .rd_addr(rd_addr), .wr(wr),
        .rd_key(rd_key), .rd_data(rd_data), .rd_link(rd_link)
    );
endmodule
`default_nettype wire

### sv/chm_entry_mem.sv
// Entry store of the chained hash map: key, data and link memories.
// Depends on chm_pkg. Link memory reset is emulated by a fill count.
`default_nettype none
module chm_entry_mem
    import chm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [AW-1:0] rd_addr,
    input  wire ent_wr_t     wr,
    output logic [31:0]      rd_key,
    output logic [31:0]      rd_data,
    output idx_t             rd_link
);
    logic [31:0] key_mem [ENTRIES];
    logic [31:0] data_mem [ENTRIES];
    idx_t link_mem [ENTRIES];
    // Entries at or above this count still hold their reset link.
    logic [IW-1:0] fill_reg;
    logic [31:0] key_q;
    logic [31:0] data_q;
    idx_t link_q;
    logic init_q;
    logic [AW-1:0] addr_q;

    // Writes to the three memories and registered reads.
    always_ff @(posedge clk)
    begin
        if (wr.we_kd)
        begin
            key_mem[wr.addr] <= wr.key;
            data_mem[wr.addr] <= wr.data;
        end
        if (wr.we_link)
        begin
            link_mem[wr.addr] <= wr.link;
        end
        key_q <= key_mem[rd_addr];
        data_q <= data_mem[rd_addr];
        link_q <= link_mem[rd_addr];
        addr_q <= rd_addr;
    end

    // Pool entries are handed out in order, so a fill count tracks the written links.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            init_q <= 1'b1;
        end
        else
        begin
            init_q <= {1'b0, rd_addr} >= fill_reg;
            if (wr.we_link && {1'b0, wr.addr} >= fill_reg)
            begin
                fill_reg <= {1'b0, wr.addr} + 1'b1;
            end
        end
    end

    assign rd_key = key_q;
    assign rd_data = data_q;
    assign rd_link = init_q ? ({1'b0, addr_q} + 1'b1) : link_q;
endmodule
`default_nettype wire

### sv/chm_ctrl.sv
// Sequencer of the chained hash map: walks chains and edits the links.
// Depends on chm_pkg; drives the entry store in chm_entry_mem.
`default_nettype none
module chm_ctrl
    import chm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [1:0]  opcode,
    input  wire logic [31:0] key,
    input  wire logic [31:0] data_in,
    output logic             busy,
    output logic             done,
    output logic [1:0]       status,
    output logic [31:0]      data_out,
    output logic [AW-1:0]    rd_addr,
    output ent_wr_t          wr,
    input  wire logic [31:0] rd_key,
    input  wire logic [31:0] rd_data,
    input  wire idx_t        rd_link
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PUTRD = 3'd1;
    localparam logic [2:0] S_PUTWR = 3'd2;
    localparam logic [2:0] S_WALK = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;
    localparam logic [2:0] S_FREE = 3'd5;

    logic [2:0] state_reg;
    idx_t head_reg [BUCKETS];
    idx_t free_reg;
    logic [1:0] op_reg;
    logic [31:0] key_reg, din_reg;
    logic [BW-1:0] bkt_reg;
    idx_t cur_reg, prev_reg, next_reg;
    logic [IW:0] steps_reg;
    logic done_reg;
    logic [1:0] status_reg;
    logic [31:0] dout_reg;
    logic [BW-1:0] bkt_in;

    assign bkt_in = key[BW-1:0];
    assign busy = state_reg != S_IDLE;
    assign done = done_reg;
    assign status = status_reg;
    assign data_out = dout_reg;

    // Read address: the free head while idle (a put needs its link), else the entry under the walk.
    always_comb
    begin
        rd_addr = cur_reg[AW-1:0];
        if (state_reg == S_IDLE)
        begin
            rd_addr = free_reg[AW-1:0];
        end
        wr = '0;
        unique case (state_reg)
            S_PUTWR:
            begin
                wr.we_kd = 1'b1;
                wr.we_link = 1'b1;
                wr.addr = cur_reg[AW-1:0];
                wr.key = key_reg;
                wr.data = din_reg;
                wr.link = head_reg[bkt_reg];
            end
            S_FREE:
            begin
                wr.we_link = 1'b1;
                wr.addr = prev_reg[AW-1:0];
                wr.link = next_reg;
            end
            S_CHECK:
            begin
                if (rd_key == key_reg)
                begin
                    wr.we_link = op_reg == OP_REMOVE;
                    wr.addr = cur_reg[AW-1:0];
                    wr.link = free_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Operation sequence; one memory read per chain step.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            for (int i = 0; i < BUCKETS; i++)
            begin
                head_reg[i] <= NIL;
            end
            free_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        op_reg <= opcode;
                        key_reg <= key;
                        din_reg <= data_in;
                        bkt_reg <= bkt_in;
                        prev_reg <= NIL;
                        steps_reg <= '0;
                        cur_reg <= opcode == OP_PUT ? free_reg : head_reg[bkt_in];
                        status_reg <= ST_OK;
                        dout_reg <= '0;
                        if (opcode == OP_PUT)
                        begin
                            if (is_valid(free_reg))
                            begin
                                state_reg <= S_PUTRD;
                            end
                            else
                            begin
                                status_reg <= ST_FULL;
                                done_reg <= 1'b1;
                            end
                        end
                        else if (opcode == OP_GET || opcode == OP_REMOVE)
                        begin
                            state_reg <= S_WALK;
                        end
                        else
                        begin
                            done_reg <= 1'b1;
                        end
                    end
                end
                S_PUTRD:
                begin
                    free_reg <= is_valid(rd_link) ? rd_link : NIL;
                    state_reg <= S_PUTWR;
                end
                S_PUTWR:
                begin
                    head_reg[bkt_reg] <= cur_reg;
                    done_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_WALK:
                begin
                    if (!is_valid(cur_reg) || steps_reg >= (IW+1)'(ENTRIES))
                    begin
                        status_reg <= ST_NOT_FOUND;
                        done_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (rd_key == key_reg)
                    begin
                        if (op_reg == OP_GET)
                        begin
                            dout_reg <= rd_data;
                            done_reg <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            free_reg <= cur_reg;
                            next_reg <= is_valid(rd_link) ? rd_link : NIL;
                            if (is_valid(prev_reg))
                            begin
                                state_reg <= S_FREE;
                            end
                            else
                            begin
                                head_reg[bkt_reg] <= is_valid(rd_link) ? rd_link : NIL;
                                done_reg <= 1'b1;
                                state_reg <= S_IDLE;
                            end
                        end
                    end
                    else
                    begin
                        prev_reg <= cur_reg;
                        cur_reg <= rd_link;
                        steps_reg <= steps_reg + 1'b1;
                        state_reg <= S_WALK;
                    end
                end
                S_FREE:
                begin
                    done_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

### sv/chm_checker.sv
// Port-level checker for the chained hash map unit, bound to the top level.
// Depends on chm_pkg for the status codes.
`default_nettype none
module chm_checker
    import chm_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        done,
    input wire logic [1:0]  status,
    input wire logic [31:0] data_out
);
    // An accepted word is answered at once or makes the unit busy.
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy || done) else $error("start lost");
    // A result closes the operation.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("done while busy");
    // Data out is zero unless the word reports success.
    a_dout: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != ST_OK |-> data_out == 32'd0) else $error("dout");
    // Status never carries the unused code.
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> status != 2'd3) else $error("status code");
endmodule

bind chained_hash_map_unit chm_checker u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .status(status), .data_out(data_out)
);
`default_nettype wire
